// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define LMS_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is low.
`define LMS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lms_pkg.sv =====
// ----------------------------------------------------------------------------
// Lap mini-sector timing package
// Constants, request types and state encoding shared by the block's files.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int ZONES    = 48;
  localparam int SECTORS  = 3;
  localparam int PER      = ZONES / SECTORS;
  localparam int FULL_LAP = 65536;

  localparam int PW   = 17;
  localparam int TW   = 32;
  localparam int AW   = $clog2(ZONES + 1);
  localparam int NBW  = $clog2(ZONES + 2);
  localparam int MW   = PW + $clog2(ZONES + 1);
  localparam int JW   = (PER > 1) ? $clog2(PER) : 1;
  localparam int SW   = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int DVW  = TW + JW;
  localparam int DDW  = 64;
  localparam int QW   = TW + 1;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_SECTOR = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] progress;
    logic [31:0] sample_time;
    logic [1:0]  sector_index;
    logic [31:0] sector_time;
  } in_t;

  typedef struct packed {
    logic [5:0]  zone_index;
    logic [31:0] zone_time;
    logic        zone_valid;
    logic        last_zone;
  } out_t;

  typedef struct packed {
    logic           start;
    logic [DDW-1:0] dividend;
    logic [DVW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_CROSS,
    ST_CWAIT,
    ST_GRP,
    ST_RD0,
    ST_RD1,
    ST_ZT,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/lms_div.sv =====
// ----------------------------------------------------------------------------
// Lap mini-sector timing divider
// Restoring divider, one quotient bit per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module lms_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lms_pkg::div_req_t req_i,
  output lms_pkg::div_rsp_t rsp_o
);

  localparam int CW = $clog2(lms_pkg::DDW + 1);

  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [lms_pkg::DDW-1:0] dq_q, dq_d;
  logic [lms_pkg::DVW-1:0] rem_q, rem_d;
  logic [lms_pkg::DVW-1:0] den_q, den_d;
  logic [lms_pkg::DVW:0]   rem_sh;
  logic                    ge;
  logic                    round_up;

  assign rem_sh = {rem_q, dq_q[lms_pkg::DDW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dq_d   = dq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(lms_pkg::DDW);
      dq_d   = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      dq_d  = {dq_q[lms_pkg::DDW-2:0], ge};
      rem_d = ge ? lms_pkg::DVW'(rem_sh - {1'b0, den_q}) : lms_pkg::DVW'(rem_sh);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign round_up   = {rem_q, 1'b0} >= {1'b0, den_q};
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q[lms_pkg::QW-1:0] + lms_pkg::QW'(round_up);

endmodule

// ===== rtl/lap_minisector_timing.sv =====
// ----------------------------------------------------------------------------
// Lap mini-sector timing
// Interpolates zone boundary crossing times and reports zone durations, optionally scaled.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (valid/stall) and carry a mode: a lap
// sample, a measured sector time, or a finish. Results leave on the out
// channel, one per zone, only after a finish; last_zone marks the final one.
// A sector time request is stored while idle. At the first sample of a lap
// ST_FIRST writes every boundary reached; later samples go through ST_CROSS
// and ST_CWAIT, at most one run of the 64-step shared divider per boundary
// crossed. A finish visits ST_GRP per sector group and ST_RD0, ST_RD1, ST_ZT
// and ST_OUT per zone to read both boundary times from the boundary memory,
// plus a divider run per zone of a scaled sector and a summing pass through
// ST_RD0, ST_RD1 and ST_ZT per zone ahead of each scaled sector.
// The input stalls while any request is in progress. Results go through an
// output register; a stalled result holds and the block waits on it.
// Reset clears the lap state and the measured sector times at once; the
// boundary memory needs no clearing since unwritten entries are never used.
// After the last zone the lap state clears for the next lap.
// ----------------------------------------------------------------------------
module lap_minisector_timing (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lms_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lms_pkg::out_t out_data_o
);

  localparam int AW  = lms_pkg::AW;
  localparam int NBW = lms_pkg::NBW;
  localparam int MW  = lms_pkg::MW;
  localparam int PW  = lms_pkg::PW;
  localparam int TW  = lms_pkg::TW;
  localparam int JW  = lms_pkg::JW;
  localparam int SW  = lms_pkg::SW;
  localparam int DVW = lms_pkg::DVW;
  localparam int DDW = lms_pkg::DDW;

  lms_pkg::state_e state_q, state_d;

  logic [NBW-1:0] nb_q, nb_d;
  logic [PW-1:0]  pm_q, pm_d;
  logic [TW-1:0]  pt_q, pt_d;
  logic [1:0]     sc_q, sc_d;
  logic [TW-1:0]  meas_q [lms_pkg::SECTORS];
  logic [TW-1:0]  meas_d [lms_pkg::SECTORS];

  logic [PW-1:0]  p_q, p_d;
  logic [TW-1:0]  t_q, t_d;
  logic [AW-1:0]  cur_q, cur_d;
  logic [AW-1:0]  base_q, base_d;
  logic [AW-1:0]  g_q, g_d;
  logic [JW-1:0]  j_q, j_d;
  logic           pass_sum_q, pass_sum_d;
  logic           scale_q, scale_d;
  logic [DVW-1:0] sum_q, sum_d;
  logic [TW-1:0]  b0_q, b0_d;
  logic [TW-1:0]  zt_q, zt_d;

  logic           out_valid_q, out_valid_d;
  lms_pkg::out_t  out_q, out_d;

  logic [TW-1:0]  mem [lms_pkg::ZONES + 1];
  logic           we;
  logic [AW-1:0]  waddr;
  logic [TW-1:0]  wdata;
  logic [AW-1:0]  raddr;
  logic [TW-1:0]  rdata_q;

  lms_pkg::div_req_t div_req;
  lms_pkg::div_rsp_t div_rsp;

  logic           in_acc;
  logic           out_free;
  logic [PW-1:0]  pc;
  logic [MW-1:0]  bnd_pos, p_pos, pm_pos, den, num;
  logic           more_bnd;
  logic           neg;
  logic [TW-1:0]  mag;
  logic [54:0]    cprod;
  logic [TW-1:0]  zt_w;
  logic           zv_w;
  logic [TW-1:0]  meas_sel;
  logic [DVW-1:0] sum_fin;
  logic [AW:0]    grp_end;

  lms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = state_q != lms_pkg::ST_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pc       = (in_data_i.progress > PW'(lms_pkg::FULL_LAP)) ?
                    PW'(lms_pkg::FULL_LAP) : in_data_i.progress;
  assign bnd_pos  = MW'(nb_q) << 16;
  assign p_pos    = MW'(p_q) * MW'(lms_pkg::ZONES);
  assign pm_pos   = MW'(pm_q) * MW'(lms_pkg::ZONES);
  assign den      = p_pos - pm_pos;
  assign num      = bnd_pos - pm_pos;
  assign more_bnd = (nb_q <= NBW'(lms_pkg::ZONES)) && (bnd_pos <= p_pos);
  assign neg      = t_q < pt_q;
  assign mag      = neg ? pt_q - t_q : t_q - pt_q;
  assign cprod    = 55'(mag) * 55'(num);

  assign zv_w     = (sc_q == 2'd2) && (NBW'(cur_q) + 1'b1 < nb_q);
  assign zt_w     = (zv_w && rdata_q > b0_q) ? rdata_q - b0_q : '0;
  assign meas_sel = (g_q < AW'(lms_pkg::SECTORS)) ? meas_q[g_q[SW-1:0]] : '0;
  assign sum_fin  = sum_q + DVW'(zt_w);
  assign grp_end  = ((AW + 1)'(g_q) + 1'b1) * (AW + 1)'(lms_pkg::PER);

  always_comb begin
    state_d     = state_q;
    nb_d        = nb_q;
    pm_d        = pm_q;
    pt_d        = pt_q;
    sc_d        = sc_q;
    meas_d      = meas_q;
    p_d         = p_q;
    t_d         = t_q;
    cur_d       = cur_q;
    base_d      = base_q;
    g_d         = g_q;
    j_d         = j_q;
    pass_sum_d  = pass_sum_q;
    scale_d     = scale_q;
    sum_d       = sum_q;
    b0_d        = b0_q;
    zt_d        = zt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = nb_q[AW-1:0];
    wdata       = t_q;
    raddr       = cur_q;
    div_req     = '0;

    unique case (state_q)
      lms_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.mode)
            lms_pkg::MODE_SAMPLE: begin
              t_d = in_data_i.sample_time;
              if (sc_q == 2'd0) begin
                p_d     = pc;
                state_d = lms_pkg::ST_FIRST;
              end else begin
                p_d     = (pc < pm_q) ? pm_q : pc;
                state_d = lms_pkg::ST_CROSS;
              end
            end
            lms_pkg::MODE_SECTOR: begin
              if (in_data_i.sector_index < 2'(lms_pkg::SECTORS)) begin
                meas_d[in_data_i.sector_index[SW-1:0]] = in_data_i.sector_time;
              end
            end
            lms_pkg::MODE_FINISH: begin
              cur_d   = '0;
              g_d     = '0;
              j_d     = '0;
              state_d = lms_pkg::ST_GRP;
            end
            default: begin
            end
          endcase
        end
      end
      lms_pkg::ST_FIRST: begin
        if (more_bnd) begin
          we   = 1'b1;
          nb_d = nb_q + 1'b1;
        end else begin
          pm_d    = p_q;
          pt_d    = t_q;
          sc_d    = 2'd1;
          state_d = lms_pkg::ST_IDLE;
        end
      end
      lms_pkg::ST_CROSS: begin
        if (more_bnd) begin
          if (den == '0) begin
            we   = 1'b1;
            nb_d = nb_q + 1'b1;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DDW'(cprod);
            div_req.divisor  = DVW'(den);
            state_d          = lms_pkg::ST_CWAIT;
          end
        end else begin
          pm_d    = p_q;
          pt_d    = t_q;
          sc_d    = 2'd2;
          state_d = lms_pkg::ST_IDLE;
        end
      end
      lms_pkg::ST_CWAIT: begin
        if (div_rsp.done) begin
          we      = 1'b1;
          wdata   = neg ? pt_q - div_rsp.quot[TW-1:0] : pt_q + div_rsp.quot[TW-1:0];
          nb_d    = nb_q + 1'b1;
          state_d = lms_pkg::ST_CROSS;
        end
      end
      lms_pkg::ST_GRP: begin
        if (meas_sel != '0 && sc_q == 2'd2 && grp_end < (AW + 1)'(nb_q)) begin
          pass_sum_d = 1'b1;
          sum_d      = '0;
          base_d     = cur_q;
        end else begin
          pass_sum_d = 1'b0;
          scale_d    = 1'b0;
        end
        state_d = lms_pkg::ST_RD0;
      end
      lms_pkg::ST_RD0: begin
        raddr   = cur_q;
        state_d = lms_pkg::ST_RD1;
      end
      lms_pkg::ST_RD1: begin
        raddr   = cur_q + 1'b1;
        b0_d    = rdata_q;
        state_d = lms_pkg::ST_ZT;
      end
      lms_pkg::ST_ZT: begin
        if (pass_sum_q) begin
          state_d = lms_pkg::ST_RD0;
          if (j_q == JW'(lms_pkg::PER - 1)) begin
            sum_d      = sum_fin;
            scale_d    = sum_fin != '0;
            pass_sum_d = 1'b0;
            cur_d      = base_q;
            j_d        = '0;
          end else begin
            sum_d = sum_fin;
            cur_d = cur_q + 1'b1;
            j_d   = j_q + 1'b1;
          end
        end else if (scale_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = DDW'(zt_w) * DDW'(meas_sel);
          div_req.divisor  = sum_q;
          state_d          = lms_pkg::ST_DIV;
        end else begin
          zt_d    = zt_w;
          state_d = lms_pkg::ST_OUT;
        end
      end
      lms_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          zt_d    = div_rsp.quot[TW-1:0];
          state_d = lms_pkg::ST_OUT;
        end
      end
      lms_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.zone_index    = 6'(cur_q);
          out_d.zone_time     = zt_q;
          out_d.zone_valid    = zv_w;
          out_d.last_zone     = cur_q == AW'(lms_pkg::ZONES - 1);
          if (cur_q == AW'(lms_pkg::ZONES - 1)) begin
            nb_d = '0;
            pm_d = '0;
            pt_d = '0;
            sc_d = '0;
            for (int s = 0; s < lms_pkg::SECTORS; s++) begin
              meas_d[s] = '0;
            end
            state_d = lms_pkg::ST_IDLE;
          end else begin
            cur_d = cur_q + 1'b1;
            if (j_q == JW'(lms_pkg::PER - 1)) begin
              j_d     = '0;
              g_d     = g_q + 1'b1;
              state_d = lms_pkg::ST_GRP;
            end else begin
              j_d     = j_q + 1'b1;
              state_d = lms_pkg::ST_RD0;
            end
          end
        end
      end
      default: begin
        state_d = lms_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lms_pkg::ST_IDLE;
      nb_q        <= '0;
      pm_q        <= '0;
      pt_q        <= '0;
      sc_q        <= '0;
      for (int s = 0; s < lms_pkg::SECTORS; s++) begin
        meas_q[s] <= '0;
      end
      cur_q       <= '0;
      g_q         <= '0;
      j_q         <= '0;
      pass_sum_q  <= 1'b0;
      scale_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nb_q        <= nb_d;
      pm_q        <= pm_d;
      pt_q        <= pt_d;
      sc_q        <= sc_d;
      meas_q      <= meas_d;
      cur_q       <= cur_d;
      g_q         <= g_d;
      j_q         <= j_d;
      pass_sum_q  <= pass_sum_d;
      scale_q     <= scale_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    t_q    <= t_d;
    base_q <= base_d;
    sum_q  <= sum_d;
    b0_q   <= b0_d;
    zt_q   <= zt_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule

// ===== rtl/lms_checker.sv =====
// ----------------------------------------------------------------------------
// Lap mini-sector timing checker
// Port-level assertions on the block's results and input stall, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lms_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input lms_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input lms_pkg::out_t out_data_o
);

  `LMS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `LMS_ASSERT(a_invalid_zero, clk_i, rst_ni, out_valid_o && !out_data_o.zone_valid |-> out_data_o.zone_time == 32'd0, "invalid zone has nonzero time")
  `LMS_ASSERT(a_last_index, clk_i, rst_ni, out_valid_o && out_data_o.last_zone |-> out_data_o.zone_index == 6'(lms_pkg::ZONES - 1), "last flag on wrong zone")
  `LMS_ASSERT(a_finish_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && in_data_i.mode == lms_pkg::MODE_FINISH |=> in_stall_o, "finish request did not occupy the block")

endmodule

bind lap_minisector_timing lms_checker u_lms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
